// ===== hw/rtl/lsac_pkg.sv =====
// Shared types and constants for the set-associative LRU tag store.
package lsac_pkg;

  localparam int ADDR_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_WAYS_IN_USE = 2'd1,
    CFG_OFFSET_BITS = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic [1:0]        hits_now;
    logic              missed;
    logic              evicted;
    logic [4:0]        set_number;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  evict_total;
  } result_t;

endpackage

// ===== hw/rtl/lsac_if.sv =====
// Valid/ready channel interface carrying one payload.
interface lsac_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lsac_front.sv =====
// Front end: splits the address into set and tag, stamps the access, queues it.
module lsac_front
  import lsac_pkg::*;
#(
  parameter int SET_COUNT = 32,
  parameter int SET_W     = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          set_bits,
  input  logic [5:0]          offset_bits,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [ADDR_W-1:0]   in_address,
  output logic                q_valid,
  input  logic                q_ready,
  output logic [1:0]          q_op,
  output logic [SET_W-1:0]    q_set,
  output logic [ADDR_W-1:0]   q_tag,
  output logic [STAMP_W-1:0]  q_stamp
);

  localparam int ENT_W = 2 + SET_W + ADDR_W + STAMP_W;

  logic [STAMP_W-1:0] access_count;
  logic [ENT_W-1:0]   fifo [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         fill;
  logic [ADDR_W-1:0]  above, set64, tag;
  logic [6:0]         tshift;
  logic [SET_W-1:0]   set_red;
  logic [SET_W-1:0]   set_tab [128];
  logic               push, pop;

  // constant table: set field (at most 7 bits) modulo SET_COUNT
  always_comb begin
    for (int i = 0; i < 128; i++) set_tab[i] = SET_W'(i % SET_COUNT);
  end

  always_comb begin
    above  = in_address >> offset_bits;
    set64  = above & ((64'd1 << set_bits) - 64'd1);
    tshift = {1'b0, offset_bits} + {4'd0, set_bits};
    tag    = (tshift < 7'd64) ? (in_address >> tshift[5:0]) : '0;
    // set64 < 128: reduce modulo SET_COUNT by table lookup
    set_red = set_tab[set64[6:0]];
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign {q_op, q_set, q_tag, q_stamp} = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= {in_operation, set_red, tag, access_count};
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
      access_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
        access_count <= access_count + 1'b1;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  a_stamp_adv: assert property (@(posedge clk) disable iff (rst)
    push |=> access_count == $past(access_count) + 1'b1)
    else $error("stamp did not advance");
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !in_ready)
    else $error("accepted into full queue");
`endif
endmodule

// ===== hw/rtl/lsac_back.sv =====
// Back end: reads a set, compares ways, picks the LRU victim, writes the set back.
module lsac_back
  import lsac_pkg::*;
#(
  parameter int SET_COUNT = 32,
  parameter int WAY_COUNT = 8,
  parameter int SET_W     = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          ways_in_use,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [1:0]          q_op,
  input  logic [SET_W-1:0]    q_set,
  input  logic [ADDR_W-1:0]   q_tag,
  input  logic [STAMP_W-1:0]  q_stamp,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_data
);

  localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int LINE_W = ADDR_W + STAMP_W;

  bk_state_t state, state_next;
  logic [LINE_W-1:0]   mem [SET_COUNT][WAY_COUNT];
  logic [LINE_W-1:0]   rd_line [WAY_COUNT];
  logic [WAY_COUNT-1:0] valid [SET_COUNT];

  logic [1:0]          op_r;
  logic [SET_W-1:0]    set_r;
  logic [ADDR_W-1:0]   tag_r;
  logic [STAMP_W-1:0]  stamp_r, acc_r;
  logic [CNT_W-1:0]    hit_cnt, miss_cnt, evict_cnt;

  logic [WAY_W:0]      ways;
  logic [WAY_COUNT-1:0] vrow, match;
  logic                hit, any_inv, take, mem_we;
  logic [WAY_W-1:0]    hit_way, inv_way, old_way, sel_way;
  logic [STAMP_W-1:0]  best_age, age;
  logic [1:0]          hits;
  logic                evict;
  logic [4:0]          set5;

  always_comb begin
    if (ways_in_use == 4'd0) ways = (WAY_W+1)'(1);
    else if ({1'b0, ways_in_use} > 5'(WAY_COUNT)) ways = (WAY_W+1)'(WAY_COUNT);
    else ways = (WAY_W+1)'(ways_in_use);
  end

  always_comb begin
    vrow = valid[set_r];
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    old_way = '0; best_age = '0;
    for (int w = WAY_COUNT-1; w >= 0; w--) begin
      match[w] = (w < int'(ways)) && vrow[w] && (rd_line[w][LINE_W-1:STAMP_W] == tag_r);
      if (match[w]) begin hit = 1'b1; hit_way = WAY_W'(w); end
      if (w < int'(ways) && !vrow[w]) begin any_inv = 1'b1; inv_way = WAY_W'(w); end
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      age = acc_r - rd_line[w][STAMP_W-1:0];
      if (w < int'(ways) && (w == 0 || age > best_age)) begin
        best_age = age; old_way = WAY_W'(w);
      end
    end
    sel_way = hit ? hit_way : (any_inv ? inv_way : old_way);
    evict = !hit && !any_inv;
    // modify: second pass always hits the line just touched
    hits = (op_r == OP_NONE) ? 2'd0 : ({1'b0, hit} + {1'b0, op_r == OP_MODIFY});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid && (!out_valid || out_ready)) state_next = BK_READ;
      BK_READ: state_next = BK_EXEC;
      BK_EXEC: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    take   = (state == BK_IDLE) && (state_next == BK_READ);
    q_ready = take;
    mem_we = (state == BK_EXEC) && (op_r != OP_NONE);
  end

  assign set5 = 5'(set_r);

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= q_op; set_r <= q_set; tag_r <= q_tag;
      stamp_r <= q_stamp; acc_r <= q_stamp;
    end
    if (state == BK_READ) rd_line <= mem[set_r];
    if (mem_we) mem[set_r][sel_way] <= {tag_r, stamp_r};
    if (state == BK_EXEC) begin
      out_data.hits_now   <= hits;
      out_data.missed     <= (op_r != OP_NONE) && !hit;
      out_data.evicted    <= (op_r != OP_NONE) && evict;
      out_data.set_number <= set5;
      out_data.hit_total  <= hit_cnt + CNT_W'(hits);
      out_data.miss_total <= miss_cnt + CNT_W'((op_r != OP_NONE) && !hit);
      out_data.evict_total <= evict_cnt + CNT_W'((op_r != OP_NONE) && evict);
    end
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      hit_cnt <= '0; miss_cnt <= '0; evict_cnt <= '0;
      for (int s = 0; s < SET_COUNT; s++) valid[s] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == BK_EXEC) begin
        out_valid <= 1'b1;
        if (op_r != OP_NONE) begin
          hit_cnt   <= hit_cnt + CNT_W'(hits);
          miss_cnt  <= miss_cnt + CNT_W'(!hit);
          evict_cnt <= evict_cnt + CNT_W'(evict);
          valid[set_r][sel_way] <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    state == BK_EXEC && op_r != OP_NONE |-> $onehot({hit, !hit && any_inv, evict}))
    else $error("lookup outcome not unique");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    state == BK_READ |=> state == BK_EXEC)
    else $error("back end sequence broken");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == BK_EXEC |=> out_valid)
    else $error("result not posted");
`endif
endmodule

// ===== hw/rtl/lru_set_assoc_cache_tag_model.sv =====
// Top level of the set-associative LRU cache tag store.
// Each access passes through the back end's three-state sequencer (take from idle, set read,
// compare and write-back), which takes the next access only from idle and only while the
// result register is free or being read; the result is registered in the write-back state.
// The front queue of two entries lets accesses arrive while one executes. A modify's second
// pass always hits and is folded into the same write-back. No clearing pass is needed:
// per-line valid bits clear at reset.
module lru_set_assoc_cache_tag_model
  import lsac_pkg::*;
#(
  parameter int SET_COUNT = 32,
  parameter int WAY_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  lsac_if.sink             in_ch,
  lsac_if.source           out_ch
);

  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

  logic [2:0] set_bits;
  logic [3:0] ways_in_use;
  logic [5:0] offset_bits;

  logic                q_valid, q_ready;
  logic [1:0]          q_op;
  logic [SET_W-1:0]    q_set;
  logic [ADDR_W-1:0]   q_tag;
  logic [STAMP_W-1:0]  q_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= '0; ways_in_use <= 4'd1; offset_bits <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SET_BITS:    set_bits    <= cfg_data[2:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  lsac_front #(.SET_COUNT(SET_COUNT), .SET_W(SET_W)) u_front (
    .clk, .rst, .set_bits, .offset_bits,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.payload.operation), .in_address(in_ch.payload.address),
    .q_valid, .q_ready, .q_op, .q_set, .q_tag, .q_stamp
  );

  lsac_back #(.SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .SET_W(SET_W)) u_back (
    .clk, .rst, .ways_in_use, .q_valid, .q_ready, .q_op, .q_set, .q_tag, .q_stamp,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload)
  );

endmodule
